// ===== rtl/rsws_pkg.sv =====
// Shared types and constants for the reference stack with stealing.
// No dependencies; imported by the interfaces and by every RTL module except rsws_ram.
`default_nettype none

package rsws_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 64;
    localparam int CLASS_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int FILL_W   = 9;
    localparam int SLOT_W   = VALUE_W + CLASS_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RECORD = 2'd0,
        OP_POP    = 2'd1,
        OP_STEAL  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_STEAL
    } t_state;

    typedef enum logic {
        PU_INC,
        PU_DEC
    } t_pu_op;

    // Compare results of the pointer unit
    typedef struct packed {
        logic a_zero;
        logic a_full;
        logic res_full;
    } t_pu_flags;

endpackage

`default_nettype wire

// ===== rtl/rsws_if.sv =====
// Command and response channel interfaces (valid/ready plus payload).
// Depends on rsws_pkg for field widths.
`default_nettype none

interface rsws_cmd_if
    import rsws_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  ref_value;
    logic [CLASS_W-1:0]  class_id;
    logic [INDEX_W-1:0]  steal_index;

    modport source (output valid, output opcode, output ref_value, output class_id,
                    output steal_index, input ready);
    modport sink   (input valid, input opcode, input ref_value, input class_id,
                    input steal_index, output ready);
endinterface

interface rsws_rsp_if
    import rsws_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               success;
    logic [VALUE_W-1:0] value_out;
    logic [CLASS_W-1:0] class_out;
    logic               bad_request;
    logic [FILL_W-1:0]  fill_level;

    modport source (output valid, output success, output value_out, output class_out,
                    output bad_request, output fill_level, input ready);
    modport sink   (input valid, input success, input value_out, input class_out,
                    input bad_request, input fill_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/reference_stack_with_stealing.sv =====
// Reference stack with stealing: ENTRIES slots of {class id, 64-bit value} and a top pointer.
// Depends on rsws_pkg, rsws_if, rsws_ram and rsws_ptr_unit.
//
// Channels: i_cmd carries one command beat (record, local pop, remote steal); o_rsp returns
// exactly one response beat per command. Both are valid/ready; a beat moves when both are high.
// One command is in flight at a time: i_cmd.ready is high only while the sequencer is idle.
// Path from command accept to response valid (output slot free):
//   record, bad steal index, unused opcode, pop on empty stack: answered from the execute state
//   steal in range: execute state, then one slot RAM read in the steal state
//   local pop: execute state, then a scan of the slots (one per cycle while the output
//   register is free; the scan stops at the first nonzero value or at the bottom). The
//   single-port-read slot RAM and the one shared pointer adder set this sequence; a new
//   command is taken the cycle after the response is loaded.
// Reset: synchronous, active low. Afterwards a clearing pass writes zero to every slot,
// one per cycle; i_cmd.ready stays low until it completes.
// Stall: a finished response sits in the output register until o_rsp.ready; the
// sequencer holds (no RAM write, no pointer update) until that register frees up.
`default_nettype none

module reference_stack_with_stealing import rsws_pkg::*; #(
    parameter int ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsws_cmd_if.sink    i_cmd,
    rsws_rsp_if.source  o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int PTR_W = $clog2(ENTRIES + 1);
    localparam int LAST  = ENTRIES - 1;

    // Sequencer and pointer state
    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_top, n_top;
    logic [IDX_W-1:0]    r_addr, n_addr;   // clear counter, then slot being read

    // Latched command
    logic [OPCODE_W-1:0] r_op;
    logic [VALUE_W-1:0]  r_val;
    logic [CLASS_W-1:0]  r_cls;
    logic [INDEX_W-1:0]  r_idx;

    // Output register
    logic                r_out_valid;
    logic                r_success;
    logic [VALUE_W-1:0]  r_value;
    logic [CLASS_W-1:0]  r_class;
    logic                r_bad;
    logic [FILL_W-1:0]   r_fill;

    // Response being formed this cycle
    logic                load_out;
    logic                res_success;
    logic [VALUE_W-1:0]  res_value;
    logic [CLASS_W-1:0]  res_class;
    logic                res_bad;
    logic [FILL_W-1:0]   res_fill;

    // Slot RAM
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [SLOT_W-1:0]   ram_wdata;
    logic [SLOT_W-1:0]   rd_data;
    logic [VALUE_W-1:0]  rd_val;
    logic [CLASS_W-1:0]  rd_cls;

    // Shared pointer unit
    t_pu_op              pu_op;
    logic [PTR_W-1:0]    pu_a;
    logic [PTR_W-1:0]    pu_res;
    t_pu_flags           pu_flags;

    logic                accept;
    logic                out_free;
    logic                steal_ok;
    logic                addr_last;
    logic                val_nz;

    assign accept    = i_cmd.valid && i_cmd.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign steal_ok  = (32'(r_idx) < 32'(ENTRIES));
    assign addr_last = (r_addr == IDX_W'(LAST));
    assign rd_val    = rd_data[VALUE_W-1:0];
    assign rd_cls    = rd_data[SLOT_W-1:VALUE_W];
    assign val_nz    = (rd_val != '0);

    assign i_cmd.ready = (r_state == ST_IDLE);

    // Read address always follows n_addr, so rd_data holds the slot at r_addr.
    rsws_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_addr),
        .o_rdata (rd_data)
    );

    rsws_ptr_unit #(
        .ENTRIES (ENTRIES)
    ) u_ptr_unit (
        .i_op    (pu_op),
        .i_a     (pu_a),
        .o_res   (pu_res),
        .o_flags (pu_flags)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (addr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    if (r_op == OP_POP && !pu_flags.a_zero) begin
                        n_state = ST_SCAN;
                    end else if (r_op == OP_STEAL && steal_ok) begin
                        n_state = ST_STEAL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (out_free && (val_nz || pu_flags.a_zero)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_STEAL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        n_top       = r_top;
        n_addr      = r_addr;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = '0;
        pu_op       = PU_DEC;
        pu_a        = PTR_W'(r_addr);
        load_out    = 1'b0;
        res_success = 1'b0;
        res_value   = '0;
        res_class   = '0;
        res_bad     = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                // zero one slot per cycle, counter runs on the shared adder
                ram_we = 1'b1;
                pu_op  = PU_INC;
                n_addr = addr_last ? '0 : IDX_W'(pu_res);
            end
            ST_IDLE: begin
            end
            ST_EXEC: begin
                pu_a = r_top;
                unique case (r_op)
                    OP_RECORD: begin
                        pu_op = PU_INC;
                        if (out_free) begin
                            load_out = 1'b1;
                            if (pu_flags.a_full) begin
                                res_bad = 1'b1;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = IDX_W'(r_top);
                                ram_wdata   = {r_cls, r_val};
                                n_top       = pu_res;
                                res_success = !pu_flags.res_full;
                            end
                        end
                    end
                    OP_POP: begin
                        if (out_free) begin
                            if (pu_flags.a_zero) begin
                                load_out = 1'b1;
                            end else begin
                                n_addr = IDX_W'(pu_res);
                            end
                        end
                    end
                    OP_STEAL: begin
                        if (out_free) begin
                            if (steal_ok) begin
                                n_addr = IDX_W'(r_idx);
                            end else begin
                                load_out = 1'b1;
                                res_bad  = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // unused opcode: empty response, nothing changes
                        load_out = out_free;
                    end
                endcase
            end
            ST_SCAN: begin
                if (out_free) begin
                    // discard the slot just read, keep its class id
                    ram_we    = 1'b1;
                    ram_wdata = {rd_cls, {VALUE_W{1'b0}}};
                    n_top     = PTR_W'(r_addr);
                    if (val_nz) begin
                        load_out    = 1'b1;
                        res_success = 1'b1;
                        res_value   = rd_val;
                        res_class   = rd_cls;
                    end else if (pu_flags.a_zero) begin
                        load_out = 1'b1;
                    end else begin
                        n_addr = IDX_W'(pu_res);
                    end
                end
            end
            ST_STEAL: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    ram_wdata   = {rd_cls, {VALUE_W{1'b0}}};
                    load_out    = 1'b1;
                    res_success = val_nz;
                    res_value   = rd_val;
                    res_class   = rd_cls;
                end
            end
            default: begin
            end
        endcase

        res_fill = FILL_W'(n_top);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_top       <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_addr  <= n_addr;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_cmd.opcode;
            r_val <= i_cmd.ref_value;
            r_cls <= i_cmd.class_id;
            r_idx <= i_cmd.steal_index;
        end
        if (load_out) begin
            r_success <= res_success;
            r_value   <= res_value;
            r_class   <= res_class;
            r_bad     <= res_bad;
            r_fill    <= res_fill;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.success     = r_success;
    assign o_rsp.value_out   = r_value;
    assign o_rsp.class_out   = r_class;
    assign o_rsp.bad_request = r_bad;
    assign o_rsp.fill_level  = r_fill;

endmodule

`default_nettype wire

// ===== rtl/rsws_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rsws_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/rsws_ptr_unit.sv =====
// Shared pointer unit: one increment/decrement adder plus zero and full compares.
// Depends on rsws_pkg (t_pu_op, t_pu_flags).
`default_nettype none

module rsws_ptr_unit import rsws_pkg::*; #(
    parameter int ENTRIES = 256
) (
    input  t_pu_op                         i_op,
    input  logic [$clog2(ENTRIES+1)-1:0]   i_a,
    output logic [$clog2(ENTRIES+1)-1:0]   o_res,
    output t_pu_flags                      o_flags
);

    localparam int PTR_W = $clog2(ENTRIES + 1);

    logic [PTR_W-1:0] step;

    always_comb begin
        unique case (i_op)
            PU_INC:  step = PTR_W'(1);
            PU_DEC:  step = '1;
            default: step = '0;
        endcase
    end

    assign o_res            = i_a + step;
    assign o_flags.a_zero   = (i_a == '0);
    assign o_flags.a_full   = (i_a == PTR_W'(ENTRIES));
    assign o_flags.res_full = (o_res == PTR_W'(ENTRIES));

endmodule

`default_nettype wire

// ===== rtl/rsws_chk.sv =====
// Port-level checker for reference_stack_with_stealing, bound to the top level.
// Depends on rsws_pkg for field widths.
`default_nettype none

module rsws_chk import rsws_pkg::*; #(
    parameter int ENTRIES = 256
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cmd_valid,
    input logic               i_cmd_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic               i_success,
    input logic [VALUE_W-1:0] i_value_out,
    input logic [CLASS_W-1:0] i_class_out,
    input logic               i_bad_request,
    input logic [FILL_W-1:0]  i_fill_level
);

    // one command in flight: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("command accepted while previous one in flight");

    // a rejected request changes nothing and returns nothing
    a_bad_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_bad_request) |->
            (!i_success && i_value_out == '0 && i_class_out == '0))
        else $error("bad request beat carries data");

    // a nonzero value is only ever returned as a success
    a_value_means_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_value_out != '0) |-> i_success)
        else $error("nonzero value without success");

    // top pointer never exceeds the stack depth
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (ENTRIES > 511 || 32'(i_fill_level) <= 32'(ENTRIES)))
        else $error("fill level beyond stack depth");

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_value_out) && $stable(i_fill_level)
             && $stable(i_success)))
        else $error("stalled response beat changed");

endmodule

bind reference_stack_with_stealing rsws_chk #(
    .ENTRIES (ENTRIES)
) u_rsws_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_success     (o_rsp.success),
    .i_value_out   (o_rsp.value_out),
    .i_class_out   (o_rsp.class_out),
    .i_bad_request (o_rsp.bad_request),
    .i_fill_level  (o_rsp.fill_level)
);

`default_nettype wire

// ===== tb/rsws_stack_checker.sv =====
// Scoreboard for the reference stack with stealing: predicts each response from accepted commands.
// Depends on rsws_pkg and the rsws_cmd_if / rsws_rsp_if channel interfaces.
`default_nettype none

module rsws_stack_checker import rsws_pkg::*; #(
    parameter int ENTRIES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rsws_cmd_if  i_cmd,
    rsws_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               success;
        logic [VALUE_W-1:0] value;
        logic [CLASS_W-1:0] cls;
        logic               bad;
        logic [FILL_W-1:0]  fill;
    } t_stack_rsp;

    // Shadow copy of the stack
    logic [VALUE_W-1:0] ref_slots   [ENTRIES];
    logic [CLASS_W-1:0] class_slots [ENTRIES];
    int unsigned        top_ptr;

    t_stack_rsp owed_rsps [$];
    int         fail_cnt = 0;
    int         rsp_beats = 0;

    // Applies one command to the shadow stack and returns the response it owes.
    function automatic t_stack_rsp exec_stack_op(input logic [OPCODE_W-1:0] op,
                                                 input logic [VALUE_W-1:0]  val,
                                                 input logic [CLASS_W-1:0]  cls,
                                                 input logic [INDEX_W-1:0]  idx);
        t_stack_rsp         r;
        logic [VALUE_W-1:0] taken;
        r = '0;
        case (op)
            OP_RECORD: begin
                if (top_ptr >= ENTRIES) begin
                    r.bad = 1'b1;
                end else begin
                    ref_slots[top_ptr]   = val;
                    class_slots[top_ptr] = cls;
                    top_ptr++;
                    r.success = (top_ptr != ENTRIES);
                end
            end
            OP_POP: begin
                // scan down, discarding cleared slots
                while (top_ptr > 0 && !r.success) begin
                    top_ptr--;
                    taken = ref_slots[top_ptr];
                    ref_slots[top_ptr] = '0;
                    if (taken != '0) begin
                        r.success = 1'b1;
                        r.value   = taken;
                        r.cls     = class_slots[top_ptr];
                    end
                end
            end
            OP_STEAL: begin
                if (int'(idx) >= ENTRIES) begin
                    r.bad = 1'b1;
                end else begin
                    // class id is reported even when the value was already cleared
                    r.value        = ref_slots[idx];
                    r.cls          = class_slots[idx];
                    ref_slots[idx] = '0;
                    r.success      = (r.value != '0);
                end
            end
            default: ;
        endcase
        r.fill = top_ptr[FILL_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_stack_rsp got;
        t_stack_rsp want;
        if (!i_rst_n) begin
            foreach (ref_slots[k]) begin
                ref_slots[k]   = '0;
                class_slots[k] = '0;
            end
            top_ptr = 0;
            owed_rsps.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                owed_rsps.push_back(exec_stack_op(i_cmd.opcode, i_cmd.ref_value,
                                                  i_cmd.class_id, i_cmd.steal_index));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.success = i_rsp.success;
                got.value   = i_rsp.value_out;
                got.cls     = i_rsp.class_out;
                got.bad     = i_rsp.bad_request;
                got.fill    = i_rsp.fill_level;
                if (owed_rsps.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                        $display("%0t: response beat %0d with no command outstanding",
                                 $realtime, rsp_beats);
                end else begin
                    want = owed_rsps.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_LIMIT) begin
                            $display("%0t: response beat %0d mismatch", $realtime, rsp_beats);
                            $display("  exp: ok=%0b val=%h cls=%h bad=%0b fill=%0d",
                                     want.success, want.value, want.cls, want.bad, want.fill);
                            $display("  got: ok=%0b val=%h cls=%h bad=%0b fill=%0d",
                                     got.success, got.value, got.cls, got.bad, got.fill);
                        end
                    end
                end
                rsp_beats++;
            end
        end
        o_fail_count = fail_cnt;
        o_pending    = owed_rsps.size();
    end

endmodule

`default_nettype wire

// ===== tb/reference_stack_with_stealing_tb.sv =====
// Top of the reference stack with stealing testbench: clock, reset, command stimulus,
// response backpressure and the verdict. Depends on rsws_pkg, rsws_if and rsws_stack_checker.
`default_nettype none

module reference_stack_with_stealing_tb import rsws_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 256;
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 3;
    // the longest pop scan runs over every slot; allow margin for a trailing stray beat
    localparam int DRAIN_CYCLES = 300;
    // far beyond the slowest legal run (clearing pass, long scans, worst stalls)
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int PHASE1_END   = 360;
    localparam int PHASE2_END   = 630;
    localparam int TOTAL_CMDS   = 900;

    // opcode 3 has no enum member; the block must answer it as a no-op
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic r_rsp_ready = 1'b0;

    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;
    int cmds_sent     = 0;
    int fail_count;
    int pending_cnt;

    rsws_cmd_if cmd_ch ();
    rsws_rsp_if rsp_ch ();

    reference_stack_with_stealing #(
        .ENTRIES (STACK_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    rsws_stack_checker #(
        .ENTRIES (STACK_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Response backpressure: ready drops at random, one decision per edge.
    always @(posedge i_clk) begin
        r_rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    assign rsp_ch.ready = r_rsp_ready;

    // Random reference value; zero (empty slot) and all-ones show up often.
    function automatic logic [VALUE_W-1:0] rand_ref();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        if (pick < 15)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Steal index: half the time near the bottom, where entries tend to live.
    function automatic logic [INDEX_W-1:0] rand_index();
        if ($urandom_range(0, 1) == 0)
            return INDEX_W'($urandom_range(0, 31));
        return INDEX_W'($urandom_range(0, 255));
    endfunction

    // Drives one command beat and returns at the edge where it is accepted.
    // Valid stays high into the next call unless that call opens a gap first.
    task automatic send_cmd(input logic [OPCODE_W-1:0] op,
                            input logic [VALUE_W-1:0]  val,
                            input logic [CLASS_W-1:0]  cls,
                            input logic [INDEX_W-1:0]  idx);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 6);
        // idle gaps land both while the block is busy and while it waits
        repeat (gap) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.ref_value   <= val;
        cmd_ch.class_id    <= cls;
        cmd_ch.steal_index <= idx;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        cmds_sent++;
    endtask

    // n commands drawn by weight; whatever the weights leave goes to the unused opcode.
    task automatic random_ops(input int n, input int rec_pct, input int pop_pct,
                              input int steal_pct);
        int                  r;
        logic [OPCODE_W-1:0] op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < rec_pct)
                op = OP_RECORD;
            else if (r < rec_pct + pop_pct)
                op = OP_POP;
            else if (r < rec_pct + pop_pct + steal_pct)
                op = OP_STEAL;
            else
                op = OP_UNUSED;
            send_cmd(op, rand_ref(), $urandom(), rand_index());
        end
    endtask

    // One burst of related traffic: filling, mixed churn, or draining.
    task automatic run_episode();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // occasional run long enough to overflow from any starting depth
            if ($urandom_range(0, 3) == 0)
                random_ops(STACK_DEPTH + 48, 90, 0, 10);
            else
                random_ops($urandom_range(16, 64), 90, 0, 10);
        end else if (kind < 6) begin
            random_ops($urandom_range(10, 40), 45, 30, 20);
        end else begin
            random_ops($urandom_range(10, 60), 10, 70, 20);
        end
    endtask

    initial begin
        // every block input known from time zero
        i_rst_n            <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.opcode      <= OP_RECORD;
        cmd_ch.ref_value   <= '0;
        cmd_ch.class_id    <= '0;
        cmd_ch.steal_index <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles lightly, receiver stalls heavily
        send_idle_pct = 28;
        rcv_idle_pct  = 54;

        // Directed: empty-stack corners, field extremes, cleared slots
        send_cmd(OP_POP,    '1, '1, '1);                   // pop on empty stack
        send_cmd(OP_STEAL,  '0, '0, 8'd0);                 // steal never-filled slot
        send_cmd(OP_STEAL,  '1, '1, 8'hFF);                // top index of the store
        send_cmd(OP_UNUSED, '1, '1, '1);                   // no-op opcode
        send_cmd(OP_RECORD, '1, '1, '0);                   // slot 0: all ones
        send_cmd(OP_RECORD, '0, 32'hA5A5_A5A5, '0);        // slot 1: zero value stored
        send_cmd(OP_RECORD, 64'd1, '0, '0);                // slot 2
        send_cmd(OP_RECORD, 64'h8000_0000_0000_0000, 32'h8000_0000, '0);  // slot 3
        send_cmd(OP_RECORD, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, '0);  // slot 4
        send_cmd(OP_STEAL,  '0, '0, 8'd1);                 // zero value, class still read
        send_cmd(OP_STEAL,  '0, '0, 8'd3);                 // live entry
        send_cmd(OP_STEAL,  '0, '0, 8'd3);                 // same slot, now cleared
        send_cmd(OP_UNUSED, '0, '0, '0);                   // fill level reported on no-op
        send_cmd(OP_POP,    '0, '0, '0);                   // takes slot 4
        send_cmd(OP_POP,    '0, '0, '0);                   // skips stolen slot 3
        send_cmd(OP_POP,    '0, '0, '0);                   // skips zero slot 1, takes 0
        send_cmd(OP_POP,    '0, '0, '0);                   // empty again
        send_cmd(OP_RECORD, 64'hDEAD_0000_0000_0001, 32'h1, '0);
        send_cmd(OP_RECORD, 64'hDEAD_0000_0000_0002, 32'h2, '0);
        send_cmd(OP_RECORD, 64'hDEAD_0000_0000_0003, 32'h3, '0);
        send_cmd(OP_STEAL,  '0, '0, 8'd2);
        send_cmd(OP_STEAL,  '0, '0, 8'd1);
        send_cmd(OP_POP,    '0, '0, '0);                   // scans two stolen slots

        // Overfill once for sure: several records land on a full stack
        random_ops(STACK_DEPTH + 48, 90, 0, 10);
        while (cmds_sent < PHASE1_END) run_episode();

        // Phase two: roles swapped
        send_idle_pct = 54;
        rcv_idle_pct  = 28;
        while (cmds_sent < PHASE2_END) run_episode();

        // Phase three: back to back on both sides
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        while (cmds_sent < TOTAL_CMDS) run_episode();
        cmd_ch.valid <= 1'b0;

        // Let every owed response arrive, then watch for strays
        @(negedge i_clk);
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hang guard
    initial begin
        #TIMEOUT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/rsws_pkg.sv
rtl/rsws_if.sv
rtl/rsws_ram.sv
rtl/rsws_ptr_unit.sv
rtl/reference_stack_with_stealing.sv
rtl/rsws_chk.sv
tb/rsws_stack_checker.sv
tb/reference_stack_with_stealing_tb.sv
